// File: sv/hppf_pkg.sv
// Shared types and constants for the histogram plateau peak finder.
// Depends on nothing; every other file imports it.
`default_nettype none

package hppf_pkg;

	localparam int BIN_W = 16;
	localparam int IDX_W = 10;

	// one result word as it leaves the tracker
	typedef struct packed {
		logic             emit;
		logic [IDX_W-1:0] peak_index;
		logic             peak_valid;
		logic             end_of_list;
	} hppf_result_t;

endpackage : hppf_pkg

`default_nettype wire

// File: sv/histogram_plateau_peak_finder_unit.sv
// Top level of the histogram plateau peak finder: input register, tracker, output register.
// Depends on hppf_pkg, hppf_tracker and hppf_result_reg.
//
// Stream histogram bins in on the slave side, bin 0 first, one word per bin, tlast on the
// final bin. Each run of equal bins whose left neighbor is lower (or that starts at bin 0)
// and whose right neighbor is lower (or that reaches the final bin) is reported as one
// peak on the master side at the rounded center (start+end+1)>>1, on the result word
// caused by the bin that reveals its right edge. The final bin always yields one word with
// tlast set; tuser says whether that word also carries a peak. A bin at position
// MAX_BINS-1 closes the histogram even without tlast, and the next bin starts a new one.
// The block takes one bin per cycle while the result register has room; a result word
// passes from the input register through the tracker, whose decision is combinational,
// into the result register, which shows it on the master side. Bins that
// give no result make no word, but every bin waits in the input register while a held
// result word that is not taken keeps the result register full; the input side keeps
// accepting while a result waits as long as the tracker output can move into the result
// register.
`default_nettype none

module histogram_plateau_peak_finder_unit #(
	parameter int MAX_BINS = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] bin_count
	input  wire         s_tlast,   // last_bin
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [9:0] peak_index, [15:10] zero
	output logic        m_tuser,   // [0] peak_valid
	output logic        m_tlast    // end_of_list
);
	import hppf_pkg::*;

	logic             valid_s1;
	logic [BIN_W-1:0] bin_s1;
	logic             last_s1;
	logic             advance;
	hppf_result_t     result;

	// accept a new word whenever the input register is empty or drains this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// hold the payload while the word waits for the tracker
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			bin_s1  <= s_tdata[BIN_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	// advance plateau state only when the staged bin moves on
	hppf_tracker #(
		.MAX_BINS(MAX_BINS)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.bin_count(bin_s1),
		.last_bin (last_s1),
		.result   (result)
	);

	hppf_result_reg u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_result(result),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule : histogram_plateau_peak_finder_unit

`default_nettype wire

// File: sv/hppf_tracker.sv
// Plateau tracking state and peak decision for one bin per cycle while en is high.
// Depends on hppf_pkg for the bin width and the result struct.
`default_nettype none

module hppf_tracker #(
	parameter int MAX_BINS = 1024
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire  [hppf_pkg::BIN_W-1:0] bin_count,
	input  wire                        last_bin,
	output hppf_pkg::hppf_result_t     result
);
	import hppf_pkg::*;

	localparam int            PW       = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_BINS - 1);

	logic [BIN_W-1:0] prev_q;
	logic [PW-1:0]    pos_q;
	logic [PW-1:0]    start_q;
	logic             rose_q;

	logic [PW-1:0]       start_n;
	logic                rose_n;
	logic                final_bin;
	logic [PW:0]         idx_sum;
	logic [PW+IDX_W-1:0] idx_ext;

	always_comb begin
		start_n            = start_q;
		rose_n             = rose_q;
		idx_sum            = '0;
		result.emit        = 1'b0;
		result.peak_valid  = 1'b0;
		result.end_of_list = 1'b0;
		final_bin          = last_bin || (pos_q == LAST_POS);

		priority if (pos_q == '0) begin
			start_n = '0;
			rose_n  = 1'b1;
		end else if (bin_count < prev_q) begin
			// falling edge closes the plateau start_q .. pos_q-1
			if (rose_q) begin
				idx_sum           = {1'b0, start_q} + {1'b0, pos_q};
				result.peak_valid = 1'b1;
				result.emit       = 1'b1;
			end
			start_n = pos_q;
			rose_n  = 1'b0;
		end else if (bin_count > prev_q) begin
			start_n = pos_q;
			rose_n  = 1'b1;
		end else begin
			// equal bin extends the current plateau
			start_n = start_q;
			rose_n  = rose_q;
		end

		if (final_bin) begin
			// plateau running into the last bin counts as a peak when it rose
			if (rose_n) begin
				idx_sum           = {1'b0, start_n} + {1'b0, pos_q} + (PW+1)'(1);
				result.peak_valid = 1'b1;
			end
			result.end_of_list = 1'b1;
			result.emit        = 1'b1;
		end

		idx_ext           = {{IDX_W{1'b0}}, idx_sum[PW:1]};
		result.peak_index = idx_ext[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			rose_q  <= 1'b1;
		end else if (en) begin
			if (final_bin) begin
				prev_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				rose_q  <= 1'b1;
			end else begin
				prev_q  <= bin_count;
				pos_q   <= pos_q + PW'(1);
				start_q <= start_n;
				rose_q  <= rose_n;
			end
		end
	end

endmodule : hppf_tracker

`default_nettype wire

// File: sv/hppf_result_reg.sv
// Output register that holds one result word until the master side takes it.
// Depends on hppf_pkg for the result struct and the index width.
`default_nettype none

module hppf_result_reg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  hppf_pkg::hppf_result_t        in_result,
	output logic                          advance,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [15:0]                   m_tdata,  // [9:0] peak_index, [15:10] zero
	output logic                          m_tuser,  // [0] peak_valid
	output logic                          m_tlast
);
	import hppf_pkg::*;

	logic             valid_q;
	logic [IDX_W-1:0] index_q;
	logic             pvalid_q;
	logic             eol_q;
	logic             room;

	// the register has room when empty or when its word leaves this cycle
	assign room    = !valid_q || m_tready;
	assign advance = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= in_valid && in_result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_result.emit) begin
			index_q  <= in_result.peak_index;
			pvalid_q <= in_result.peak_valid;
			eol_q    <= in_result.end_of_list;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(16-IDX_W){1'b0}}, index_q};
	assign m_tuser  = pvalid_q;
	assign m_tlast  = eol_q;

endmodule : hppf_result_reg

`default_nettype wire

// File: dv/tb.sv
// Testbench for histogram_plateau_peak_finder_unit: streams histograms through the block
// and checks every output word against an in-bench plateau tracker.
// Depends on hppf_pkg and the RTL of the unit; reads and writes no files.
`default_nettype none

module tb;
	import hppf_pkg::*;

	localparam int MAX_BINS = 1024;
	localparam int HALF_PERIOD = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int RUN_LIMIT = 4000000;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             valid;
		logic             eol;
	} peak_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] bin_count
	logic        s_tlast = 1'b0; // last_bin
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;        // [9:0] peak_index, [15:10] zero
	logic        m_tuser;        // [0] peak_valid
	logic        m_tlast;        // end_of_list

	// plateau tracker state, mirrors the block
	logic [BIN_W-1:0] prev_bin;
	int unsigned      bin_pos;
	int unsigned      run_start;
	logic             run_rose;

	peak_word_t expected_peaks[$];
	int         n_errors = 0;
	int         n_sent = 0;
	bit         idle_on = 1'b1;
	int         hold_req = 0;

	histogram_plateau_peak_finder_unit #(
		.MAX_BINS(MAX_BINS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// Advance the tracker by one accepted bin; queue the word it should cause, if any.
	task automatic track_bin(input logic [BIN_W-1:0] v, input logic l);
		peak_word_t  w;
		logic        hit;
		int unsigned sum;
		w = '0;
		hit = 1'b0;
		if (bin_pos == 0) begin
			run_start = 0;
			run_rose = 1'b1;
		end else if (v < prev_bin) begin
			// right edge of the plateau that ended at bin_pos-1
			if (run_rose) begin
				sum = run_start + bin_pos;
				w.idx = IDX_W'(sum >> 1);
				w.valid = 1'b1;
				hit = 1'b1;
			end
			run_start = bin_pos;
			run_rose = 1'b0;
		end else if (v > prev_bin) begin
			run_start = bin_pos;
			run_rose = 1'b1;
		end
		prev_bin = v;
		if (l || bin_pos >= MAX_BINS - 1) begin
			// final bin: its own plateau reaches the end
			if (run_rose) begin
				sum = run_start + bin_pos + 1;
				w.idx = IDX_W'(sum >> 1);
				w.valid = 1'b1;
			end
			w.eol = 1'b1;
			hit = 1'b1;
			prev_bin = '0;
			bin_pos = 0;
			run_start = 0;
			run_rose = 1'b1;
		end else begin
			bin_pos = bin_pos + 1;
		end
		if (hit)
			expected_peaks.insert(expected_peaks.size(), w);
	endtask

	// Offer one bin and hold it until accepted. Call at a rising edge; returns at the
	// edge where the word was taken.
	task automatic send_bin(input logic [BIN_W-1:0] v, input logic l);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= l;
		// inputs settle between edges, so the handshake seen at the falling edge holds
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		n_sent++;
		track_bin(v, l);
	endtask

	// One histogram of len bins; a small span gives long plateaus.
	task automatic send_histogram(input int len, input int span);
		int base;
		base = $urandom_range(0, 65535 - span);
		for (int i = 0; i < len; i++)
			send_bin(BIN_W'(base + $urandom_range(0, span)), i == len - 1);
	endtask

	task automatic send_mixed(input int count);
		int stop;
		int len;
		stop = n_sent + count;
		while (n_sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					// noise: arbitrary values, tlast at random
					send_bin(BIN_W'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
				end
				2: begin
					len = $urandom_range(1, 60);
					send_histogram(len, 65535);
				end
				default: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
						: $urandom_range(1, 12);
					send_histogram(len, $urandom_range(1, 4));
				end
			endcase
		end
	endtask

	task automatic test_directed();
		send_bin(16'd5, 1'b1);          // single bin histogram
		send_bin(16'hFFFF, 1'b1);
		send_bin(16'd0, 1'b0);          // flat histogram, one plateau end to end
		send_bin(16'd0, 1'b0);
		send_bin(16'd0, 1'b1);
		send_bin(16'd1, 1'b0);          // plain single-bin peak
		send_bin(16'd3, 1'b0);
		send_bin(16'd2, 1'b0);
		send_bin(16'd1, 1'b1);
		send_bin(16'd1, 1'b0);          // wide plateau peak
		send_bin(16'd4, 1'b0);
		send_bin(16'd4, 1'b0);
		send_bin(16'd4, 1'b0);
		send_bin(16'd2, 1'b1);
		send_bin(16'd2, 1'b0);          // right edge revealed by the final bin
		send_bin(16'hFFFF, 1'b0);
		send_bin(16'd3, 1'b1);
		send_bin(16'd5, 1'b0);          // final bin ends with no peak
		send_bin(16'd3, 1'b0);
		send_bin(16'd3, 1'b1);
		send_bin(16'd1, 1'b0);          // rise into the final bin
		send_bin(16'd2, 1'b1);
	endtask

	// Send MAX_BINS bins without tlast, so the block must close the histogram at MAX_BINS-1 on its own.
	task automatic test_max_bins();
		for (int i = 0; i < MAX_BINS; i++)
			send_bin(BIN_W'($urandom_range(0, 3)), 1'b0);
		send_bin(16'd9, 1'b1);
	endtask

	task automatic test_random();
		send_mixed(300);
	endtask

	// Stall the output for a long stretch while bins keep coming, so the input backs up.
	task automatic test_backpressure();
		hold_req = 80;
		for (int i = 0; i < 60; i++)
			send_bin((i % 2) ? 16'd1 : 16'd7, i == 59);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		send_mixed(250);
	endtask

	// output ready: random stall bursts, plus the long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				m_tready <= 1'b0;
				hold_req = hold_req - 1;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each word taken on the master side with the oldest queued expectation
	initial begin
		peak_word_t w;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_peaks.size() == 0) begin
					report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					w = expected_peaks.pop_front();
					if (m_tdata !== {6'b0, w.idx})
						report_mismatch($sformatf("peak_index got %h exp %h",
							m_tdata, {6'b0, w.idx}));
					if (m_tuser !== w.valid)
						report_mismatch($sformatf("peak_valid got %b exp %b",
							m_tuser, w.valid));
					if (m_tlast !== w.eol)
						report_mismatch($sformatf("end_of_list got %b exp %b",
							m_tlast, w.eol));
				end
			end
		end
	end

	initial begin
		#RUN_LIMIT;
		$display("[histogram_plateau_peak_finder_unit] ERROR");
		$finish;
	end

	initial begin
		prev_bin = '0;
		bin_pos = 0;
		run_start = 0;
		run_rose = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_max_bins();
		test_random();
		test_backpressure();
		test_no_idle();
		s_tvalid <= 1'b0;

		// drain: wait for every queued word, then keep waiting for strays
		while (expected_peaks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0) begin
			$display("[histogram_plateau_peak_finder_unit] OK");
		end else begin
			$display("[histogram_plateau_peak_finder_unit] ERROR");
		end
		$finish;
	end

endmodule : tb

`default_nettype wire
